>>> rtl/core/block_logger_buffer_pool_macros.svh
// Assertion macros shared by the buffer pool RTL.
`ifndef BLOCK_LOGGER_BUFFER_POOL_MACROS_SVH
`define BLOCK_LOGGER_BUFFER_POOL_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define BLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Invariant that holds at every edge out of reset.
`define BLP_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`else

`define BLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define BLP_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`endif

`endif

>>> rtl/core/blp_pkg.sv
`default_nettype none

package blp_pkg;

  localparam int BUFFERS           = 12;
  localparam int RECORDS_PER_BLOCK = 127;
  localparam int RING_DEPTH        = BUFFERS + 1;

  localparam int BUF_IDX_W = $clog2(BUFFERS);
  localparam int FREE_W    = $clog2(BUFFERS + 1);
  localparam int RING_W    = $clog2(RING_DEPTH);

  // Field widths of the item formats
  localparam int BUF_FIELD_W  = 4;
  localparam int CNT_W        = 7;
  localparam int OVR_W        = 16;
  localparam int TOTAL_W      = 24;
  localparam int FREE_FIELD_W = 4;
  localparam int STATUS_W     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_BLOCK_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_LOSS     = 2'd2;

  localparam logic [TOTAL_W-1:0] MAX_TICKS_RST  = 24'd1500;
  localparam logic [TOTAL_W-1:0] BLOCK_LIMIT_RST = 24'd256000;

  typedef enum logic [STATUS_W-1:0] {
    RUN_ACTIVE    = 2'd0,
    RUN_CLOSED    = 2'd1,
    RUN_ABORTED   = 2'd2,
    RUN_FILE_FULL = 2'd3
  } run_status_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] max_ticks;
    logic [TOTAL_W-1:0] file_block_limit;
    logic               stop_on_loss;
  } cfg_t;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic phase_a;   // stack pop, open buffer, sample slot
    logic commit;    // queue pop, card write, load result
  } dp_cmd_t;

  typedef struct packed {
    logic run_ended;
  } dp_sts_t;

  typedef struct packed {
    logic                    sample_stored;
    logic [BUF_FIELD_W-1:0]  sample_buffer;
    logic [CNT_W-1:0]        sample_slot;
    logic                    write_issue;
    logic [BUF_FIELD_W-1:0]  write_buffer;
    logic [CNT_W-1:0]        write_count;
    logic [OVR_W-1:0]        write_overrun;
    logic [TOTAL_W-1:0]      blocks_written;
    logic [TOTAL_W-1:0]      overrun_total;
    logic [FREE_FIELD_W-1:0] min_free;
    logic [STATUS_W-1:0]     run_status;
  } out_item_t;

  function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] p);
    logic [RING_W-1:0] q;
    q = (p == RING_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/blp_in_if.sv
`default_nettype none

interface blp_in_if;
  logic valid;
  logic ready;
  logic stop_request;
  logic card_ready;

  modport source (output valid, output stop_request, output card_ready, input ready);
  modport sink (input valid, input stop_request, input card_ready, output ready);
endinterface

`default_nettype wire

>>> rtl/core/blp_out_if.sv
`default_nettype none

interface blp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              sample_stored;
  logic [blp_pkg::BUF_FIELD_W-1:0]   sample_buffer;
  logic [blp_pkg::CNT_W-1:0]         sample_slot;
  logic                              write_issue;
  logic [blp_pkg::BUF_FIELD_W-1:0]   write_buffer;
  logic [blp_pkg::CNT_W-1:0]         write_count;
  logic [blp_pkg::OVR_W-1:0]         write_overrun;
  logic [blp_pkg::TOTAL_W-1:0]       blocks_written;
  logic [blp_pkg::TOTAL_W-1:0]       overrun_total;
  logic [blp_pkg::FREE_FIELD_W-1:0]  min_free;
  logic [blp_pkg::STATUS_W-1:0]      run_status;

  modport source (
    output valid, output sample_stored, output sample_buffer, output sample_slot,
    output write_issue, output write_buffer, output write_count, output write_overrun,
    output blocks_written, output overrun_total, output min_free, output run_status,
    input ready
  );
  modport sink (
    input valid, input sample_stored, input sample_buffer, input sample_slot,
    input write_issue, input write_buffer, input write_count, input write_overrun,
    input blocks_written, input overrun_total, input min_free, input run_status,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/blp_cfg.sv
`default_nettype none

module blp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::CFG_DATA_W-1:0] cfg_data,
  output blp_pkg::cfg_t                       cfg
);

  blp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        blp_pkg::CFG_MAX_TICKS:        cfg_nxt.max_ticks = cfg_data[blp_pkg::TOTAL_W-1:0];
        blp_pkg::CFG_FILE_BLOCK_LIMIT: cfg_nxt.file_block_limit =
                                         cfg_data[blp_pkg::TOTAL_W-1:0];
        blp_pkg::CFG_STOP_ON_LOSS:     cfg_nxt.stop_on_loss = cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_ticks        <= blp_pkg::MAX_TICKS_RST;
      cfg_r.file_block_limit <= blp_pkg::BLOCK_LIMIT_RST;
      cfg_r.stop_on_loss     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/blp_ctrl.sv
`default_nettype none
`include "block_logger_buffer_pool_macros.svh"

module blp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire blp_pkg::dp_sts_t sts,
  output blp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PHA  = 3'b010,
    ST_PHB  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // an ended run skips the stack step
          state_nxt = sts.run_ended ? ST_PHB : ST_PHA;
        end
      end
      ST_PHA: begin
        cmd.phase_a = 1'b1;
        state_nxt   = ST_PHB;
      end
      ST_PHB: begin
        // hold until the result register can take the item
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BLP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE, "item accepted but controller stayed idle")
  `BLP_ASSERT_NOW(a_result_from_commit, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_PHB, "result shown without a commit step")
  `BLP_ASSERT_NEXT(a_wait_holds_result, clk, rst_n, out_valid_r && !out_ready, out_valid_r, "waiting result was dropped")

endmodule

`default_nettype wire

>>> rtl/core/blp_dp.sv
`default_nettype none
`include "block_logger_buffer_pool_macros.svh"

module blp_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire blp_pkg::dp_cmd_t cmd,
  output blp_pkg::dp_sts_t   sts,
  input  wire blp_pkg::cfg_t cfg,
  input  wire logic          stop_request,
  input  wire logic          card_ready,
  output blp_pkg::out_item_t res
);

  localparam int IW = blp_pkg::BUF_IDX_W;
  localparam int FW = blp_pkg::FREE_W;
  localparam int RW = blp_pkg::RING_W;
  localparam int CW = blp_pkg::CNT_W;
  localparam int OW = blp_pkg::OVR_W;
  localparam int TW = blp_pkg::TOTAL_W;
  localparam int NB = blp_pkg::BUFFERS;
  localparam int ND = blp_pkg::RING_DEPTH;
  localparam int POOL_SUM_W = FW + 1;

  // free stack and full ring
  logic [IW-1:0] free_stack_r [NB];
  logic [IW-1:0] free_stack_nxt [NB];
  logic [FW-1:0] free_top_r, free_top_nxt;
  logic [FW-1:0] lowest_r, lowest_nxt;
  logic [IW-1:0] ring_r [ND];
  logic [IW-1:0] ring_nxt [ND];
  logic [RW-1:0] head_r, head_nxt;
  logic [RW-1:0] tail_r, tail_nxt;

  // per-buffer headers
  logic [CW-1:0] cnt_mem_r [NB];
  logic [CW-1:0] cnt_mem_nxt [NB];
  logic [OW-1:0] ovr_mem_r [NB];
  logic [OW-1:0] ovr_mem_nxt [NB];

  logic          open_valid_r, open_valid_nxt;
  logic [IW-1:0] open_buf_r, open_buf_nxt;
  logic [CW-1:0] open_cnt_r, open_cnt_nxt;
  logic [OW-1:0] pend_r, pend_nxt;
  logic [TW-1:0] lost_r, lost_nxt;
  logic [TW-1:0] written_r, written_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic          closing_r, closing_nxt;
  blp_pkg::run_status_t status_r, status_nxt;

  logic          stop_r, card_r;
  logic          s_stored_r, s_stored_nxt;
  logic [IW-1:0] s_buf_r, s_buf_nxt;
  logic [CW-1:0] s_slot_r, s_slot_nxt;
  blp_pkg::out_item_t res_r, res_nxt;

  // step A operands
  logic [TW-1:0] tick_inc;
  logic          close_a;
  logic          take;
  logic [FW-1:0] ft_dec;
  logic [IW-1:0] pop_buf;
  logic [IW-1:0] cur_buf;
  logic [CW-1:0] cur_cnt;
  logic [CW-1:0] cnt_inc;

  // step B operands
  logic [IW-1:0] wr_buf;
  logic [TW-1:0] written_inc;

  logic [RW-1:0]         ring_cnt;
  logic [POOL_SUM_W-1:0] pool_sum;

  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;
  assign close_a  = closing_r || stop_r || (tick_inc > cfg.max_ticks);
  assign take     = !open_valid_r && (free_top_r != '0);
  assign ft_dec   = free_top_r - 1'b1;
  assign pop_buf  = free_stack_r[ft_dec[IW-1:0]];
  assign cur_buf  = open_valid_r ? open_buf_r : pop_buf;
  assign cur_cnt  = open_valid_r ? open_cnt_r : '0;
  assign cnt_inc  = cur_cnt + 1'b1;

  assign wr_buf      = ring_r[tail_r];
  assign written_inc = (written_r == '1) ? written_r : written_r + 1'b1;

  always_comb begin
    logic          enq;
    logic [IW-1:0] enq_buf;
    logic [CW-1:0] enq_cnt;

    enq     = 1'b0;
    enq_buf = '0;
    enq_cnt = '0;

    free_stack_nxt = free_stack_r;
    free_top_nxt   = free_top_r;
    lowest_nxt     = lowest_r;
    ring_nxt       = ring_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_mem_nxt    = cnt_mem_r;
    ovr_mem_nxt    = ovr_mem_r;
    open_valid_nxt = open_valid_r;
    open_buf_nxt   = open_buf_r;
    open_cnt_nxt   = open_cnt_r;
    pend_nxt       = pend_r;
    lost_nxt       = lost_r;
    written_nxt    = written_r;
    tick_nxt       = tick_r;
    closing_nxt    = closing_r;
    status_nxt     = status_r;
    s_stored_nxt   = s_stored_r;
    s_buf_nxt      = s_buf_r;
    s_slot_nxt     = s_slot_r;
    res_nxt        = res_r;

    if (cmd.capture) begin
      s_stored_nxt = 1'b0;
      s_buf_nxt    = '0;
      s_slot_nxt   = '0;
    end

    if (cmd.phase_a && status_r == blp_pkg::RUN_ACTIVE) begin
      tick_nxt    = tick_inc;
      closing_nxt = close_a;
      if (close_a) begin
        // flush the open buffer
        if (open_valid_r) begin
          enq     = 1'b1;
          enq_buf = open_buf_r;
          enq_cnt = open_cnt_r;
        end
      end else begin
        if (take) begin
          free_top_nxt = ft_dec;
          if (ft_dec < lowest_r) begin
            lowest_nxt = ft_dec;
          end
          ovr_mem_nxt[pop_buf] = pend_r;
          pend_nxt             = '0;
        end
        if (!open_valid_r && !take) begin
          if (pend_r != '1) pend_nxt = pend_r + 1'b1;
          if (lost_r != '1) lost_nxt = lost_r + 1'b1;
          if (cfg.stop_on_loss) begin
            status_nxt = blp_pkg::RUN_ABORTED;
          end
        end else begin
          s_stored_nxt = 1'b1;
          s_buf_nxt    = cur_buf;
          s_slot_nxt   = cur_cnt;
          if (cnt_inc >= CW'(blp_pkg::RECORDS_PER_BLOCK)) begin
            enq     = 1'b1;
            enq_buf = cur_buf;
            enq_cnt = cnt_inc;
          end else begin
            open_valid_nxt = 1'b1;
            open_buf_nxt   = cur_buf;
            open_cnt_nxt   = cnt_inc;
          end
        end
      end
      if (enq) begin
        ring_nxt[head_r]     = enq_buf;
        head_nxt             = blp_pkg::ring_next(head_r);
        open_valid_nxt       = 1'b0;
        cnt_mem_nxt[enq_buf] = enq_cnt;
      end
    end

    if (cmd.commit) begin
      res_nxt = '0;
      if (status_r == blp_pkg::RUN_ACTIVE) begin
        if (head_r == tail_r) begin
          if (closing_r) status_nxt = blp_pkg::RUN_CLOSED;
        end else if (card_r) begin
          tail_nxt              = blp_pkg::ring_next(tail_r);
          res_nxt.write_issue   = 1'b1;
          res_nxt.write_buffer  = blp_pkg::BUF_FIELD_W'(wr_buf);
          res_nxt.write_count   = cnt_mem_r[wr_buf];
          res_nxt.write_overrun = ovr_mem_r[wr_buf];
          // return the buffer to the stack
          if (free_top_r < FW'(NB)) begin
            free_stack_nxt[free_top_r[IW-1:0]] = wr_buf;
            free_top_nxt                       = free_top_r + 1'b1;
          end
          written_nxt = written_inc;
          if (written_inc == cfg.file_block_limit) begin
            status_nxt = blp_pkg::RUN_FILE_FULL;
          end
        end
      end
      res_nxt.sample_stored  = s_stored_r;
      res_nxt.sample_buffer  = blp_pkg::BUF_FIELD_W'(s_buf_r);
      res_nxt.sample_slot    = s_slot_r;
      res_nxt.blocks_written = written_nxt;
      res_nxt.overrun_total  = lost_r;
      res_nxt.min_free       = blp_pkg::FREE_FIELD_W'(lowest_r);
      res_nxt.run_status     = status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        free_stack_r[i] <= IW'(i);
      end
      free_top_r   <= FW'(NB);
      lowest_r     <= FW'(NB);
      head_r       <= '0;
      tail_r       <= '0;
      open_valid_r <= 1'b0;
      open_buf_r   <= '0;
      pend_r       <= '0;
      lost_r       <= '0;
      written_r    <= '0;
      tick_r       <= '0;
      closing_r    <= 1'b0;
      status_r     <= blp_pkg::RUN_ACTIVE;
    end else begin
      free_stack_r <= free_stack_nxt;
      free_top_r   <= free_top_nxt;
      lowest_r     <= lowest_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      open_valid_r <= open_valid_nxt;
      open_buf_r   <= open_buf_nxt;
      pend_r       <= pend_nxt;
      lost_r       <= lost_nxt;
      written_r    <= written_nxt;
      tick_r       <= tick_nxt;
      closing_r    <= closing_nxt;
      status_r     <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ring_r     <= ring_nxt;
    cnt_mem_r  <= cnt_mem_nxt;
    ovr_mem_r  <= ovr_mem_nxt;
    open_cnt_r <= open_cnt_nxt;
    s_stored_r <= s_stored_nxt;
    s_buf_r    <= s_buf_nxt;
    s_slot_r   <= s_slot_nxt;
    res_r      <= res_nxt;
    if (cmd.capture) begin
      stop_r <= stop_request;
      card_r <= card_ready;
    end
  end

  assign sts.run_ended = (status_r != blp_pkg::RUN_ACTIVE);
  assign res           = res_r;

  // every buffer is free, open or queued
  assign ring_cnt = (head_r >= tail_r) ? head_r - tail_r : head_r + RW'(ND) - tail_r;
  assign pool_sum = POOL_SUM_W'(free_top_r) + POOL_SUM_W'(open_valid_r) + POOL_SUM_W'(ring_cnt);

  `BLP_ASSERT_ALWAYS(a_buffers_conserved, clk, rst_n, pool_sum == POOL_SUM_W'(NB), "buffer lost or duplicated")
  `BLP_ASSERT_NEXT(a_status_sticky, clk, rst_n, status_r != blp_pkg::RUN_ACTIVE, status_r == $past(status_r), "ended run changed status")
  `BLP_ASSERT_ALWAYS(a_lowest_bound, clk, rst_n, lowest_r <= free_top_r, "low-water mark above free count")

endmodule

`default_nettype wire

>>> rtl/core/block_logger_buffer_pool.sv
`default_nettype none

// Buffer pool controller for a block-based sample logger. Each input item is one
// sample tick carrying stop_request and card_ready; each tick returns exactly one
// result item with the slot the sample landed in (if any), the block sent to the
// card (if any) and the running totals and run status. Each tick runs the
// accept, free-stack/open-buffer and queue/card-write steps before the next is
// accepted; ended-run ticks skip the free-stack step. The card-write step waits
// for a free output register. The result sits in an output register, so the next
// tick is accepted while a result still waits to be taken. No clearing pass runs
// after reset. Write configuration registers (0 max_ticks, 1 file_block_limit,
// 2 stop_on_loss) through cfg_we/cfg_index/cfg_data only while idle; not checked.
module block_logger_buffer_pool (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::CFG_DATA_W-1:0] cfg_data,
  blp_in_if.sink                              in_chan,
  blp_out_if.source                           out_chan
);

  blp_pkg::cfg_t      cfg;
  blp_pkg::dp_cmd_t   cmd;
  blp_pkg::dp_sts_t   sts;
  blp_pkg::out_item_t res;
  logic               in_ready;
  logic               out_valid;

  blp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  blp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .stop_request (in_chan.stop_request),
    .card_ready   (in_chan.card_ready),
    .res          (res)
  );

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid;
  assign out_chan.sample_stored  = res.sample_stored;
  assign out_chan.sample_buffer  = res.sample_buffer;
  assign out_chan.sample_slot    = res.sample_slot;
  assign out_chan.write_issue    = res.write_issue;
  assign out_chan.write_buffer   = res.write_buffer;
  assign out_chan.write_count    = res.write_count;
  assign out_chan.write_overrun  = res.write_overrun;
  assign out_chan.blocks_written = res.blocks_written;
  assign out_chan.overrun_total  = res.overrun_total;
  assign out_chan.min_free       = res.min_free;
  assign out_chan.run_status     = res.run_status;

endmodule

`default_nettype wire
